@@ src/mpsp_pkg.sv @@
// shared types, constants and microcode rom of the min-plus shortest path engine
package mpsp_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int MAX_ITERATIONS_DEF = 64;

	localparam int WEIGHT_W = 32;
	localparam int CFG_W = 7;
	localparam logic [WEIGHT_W-1:0] INF_Q = '1;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;
	localparam logic [CFG_W-1:0] ITERATION_COUNT_RST = 7'd1;

	// config register indexes
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_ITERATION_COUNT = 1'b1;

	// function codes of an input word
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_RUN = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	// microcode step addresses
	typedef logic [3:0] step_t;
	localparam step_t STEP_IDLE = 4'd0;
	localparam step_t STEP_RUN_INIT = 4'd1;
	localparam step_t STEP_CP_RD = 4'd2;
	localparam step_t STEP_CP_WR = 4'd3;
	localparam step_t STEP_PASS_CHK = 4'd4;
	localparam step_t STEP_ENT_INIT = 4'd5;
	localparam step_t STEP_LOOP = 4'd6;
	localparam step_t STEP_DRAIN = 4'd7;
	localparam step_t STEP_WR = 4'd8;
	localparam step_t STEP_PASS_END = 4'd9;
	localparam step_t STEP_DONE = 4'd10;
	localparam step_t STEP_RDI = 4'd11;
	localparam step_t STEP_RDO = 4'd12;

	typedef enum logic [2:0] {
		COND_NEXT = 3'd0,
		COND_ALWAYS = 3'd1,
		COND_K_MORE = 3'd2,
		COND_IJ_MORE = 3'd3,
		COND_P_DONE = 3'd4,
		COND_DISPATCH = 3'd5
	} cond_t;

	// one control word; the strobes below the rom fields are filled in by the sequencer
	typedef struct packed {
		cond_t cond;
		step_t target;
		logic cp_rd;
		logic issue;
		logic dist_we;
		logic dsrc_best;
		logic best_init;
		logic k_clr;
		logic k_inc;
		logic ij_clr;
		logic ij_inc;
		logic p_clr;
		logic p_inc;
		logic rd_issue;
		logic out_run;
		logic out_read;
		logic adj_we;
		logic run_ld;
		logic rd_ld;
	} ctrl_t;

	typedef struct packed {
		logic k_last;
		logic ij_last;
		logic p_done;
	} stat_t;

	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		c = '0;
		c.cond = COND_NEXT;
		c.target = STEP_IDLE;
		case (s)
			STEP_IDLE: begin
				c.cond = COND_DISPATCH;
			end
			STEP_RUN_INIT: begin
				c.ij_clr = 1'b1;
				c.p_clr = 1'b1;
			end
			STEP_CP_RD: begin
				c.cp_rd = 1'b1;
			end
			STEP_CP_WR: begin
				c.dist_we = 1'b1;
				c.ij_inc = 1'b1;
				c.cond = COND_IJ_MORE;
				c.target = STEP_CP_RD;
			end
			STEP_PASS_CHK: begin
				c.ij_clr = 1'b1;
				c.cond = COND_P_DONE;
				c.target = STEP_DONE;
			end
			STEP_ENT_INIT: begin
				c.best_init = 1'b1;
				c.k_clr = 1'b1;
			end
			STEP_LOOP: begin
				c.issue = 1'b1;
				c.k_inc = 1'b1;
				c.cond = COND_K_MORE;
				c.target = STEP_LOOP;
			end
			STEP_DRAIN: begin
				c.cond = COND_NEXT;
			end
			STEP_WR: begin
				c.dist_we = 1'b1;
				c.dsrc_best = 1'b1;
				c.ij_inc = 1'b1;
				c.cond = COND_IJ_MORE;
				c.target = STEP_ENT_INIT;
			end
			STEP_PASS_END: begin
				c.p_inc = 1'b1;
				c.cond = COND_ALWAYS;
				c.target = STEP_PASS_CHK;
			end
			STEP_DONE: begin
				c.out_run = 1'b1;
				c.cond = COND_ALWAYS;
				c.target = STEP_IDLE;
			end
			STEP_RDI: begin
				c.rd_issue = 1'b1;
			end
			STEP_RDO: begin
				c.out_read = 1'b1;
				c.cond = COND_ALWAYS;
				c.target = STEP_IDLE;
			end
			default: begin
				c.cond = COND_ALWAYS;
				c.target = STEP_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

@@ src/mpsp_dpath.sv @@
// datapath: adjacency and distance memories, index counters, saturating min-plus unit
module mpsp_dpath #(
	parameter int MAX_NODES = mpsp_pkg::MAX_NODES_DEF,
	parameter int MAX_ITERATIONS = mpsp_pkg::MAX_ITERATIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mpsp_pkg::ctrl_t                   ctrl,
	input  logic [5:0]                        row,
	input  logic [5:0]                        col,
	input  logic [mpsp_pkg::WEIGHT_W-1:0]     weight,
	input  logic [mpsp_pkg::CFG_W-1:0]        n_raw,
	input  logic [mpsp_pkg::CFG_W-1:0]        it_raw,
	output mpsp_pkg::stat_t                   stat,
	output logic [mpsp_pkg::WEIGHT_W-1:0]     dist_rdata,
	output logic                              rd_in_range
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int AW = 2 * NW;
	localparam int DEPTH = 1 << AW;
	localparam int IW = $clog2(MAX_ITERATIONS + 1);
	localparam int DW = mpsp_pkg::WEIGHT_W;

	logic [DW-1:0] adj_mem [DEPTH];
	logic [DW-1:0] dist_mem [DEPTH];

	logic [NW-1:0] i_q, j_q, k_q, n_last_q;
	logic [NW-1:0] row_q, col_q;
	logic [IW-1:0] p_q, iters_q;
	logic          in_range_q;
	logic          issue_s1;
	logic [DW-1:0] adj_rdata_q;
	logic [DW-1:0] dist_rdata_q;
	logic [DW-1:0] best_q;

	logic          wr_in_range;
	logic [AW-1:0] adj_waddr, adj_raddr, dist_raddr, ij_addr;
	logic [DW-1:0] dist_wdata;
	logic [DW:0]   sum;
	logic [DW-1:0] term;

	assign wr_in_range = (32'(row) < MAX_NODES) && (32'(col) < MAX_NODES);
	assign adj_waddr = {NW'(row), NW'(col)};
	assign ij_addr = {i_q, j_q};
	assign adj_raddr = ctrl.cp_rd ? ij_addr : {k_q, j_q};
	assign dist_raddr = ctrl.rd_issue ? {row_q, col_q} : {i_q, k_q};
	assign dist_wdata = ctrl.dsrc_best ? best_q : adj_rdata_q;

	// infinity on either side gives a sum at or above all-ones, so one compare covers both
	assign sum = {1'b0, adj_rdata_q} + {1'b0, dist_rdata_q};
	assign term = (sum >= {1'b0, mpsp_pkg::INF_Q}) ? mpsp_pkg::INF_Q : sum[DW-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.adj_we && wr_in_range) begin
			adj_mem[adj_waddr] <= weight;
		end
		if (ctrl.cp_rd || ctrl.issue) begin
			adj_rdata_q <= adj_mem[adj_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.dist_we) begin
			dist_mem[ij_addr] <= dist_wdata;
		end
		if (ctrl.issue || ctrl.rd_issue) begin
			dist_rdata_q <= dist_mem[dist_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.best_init) begin
			best_q <= mpsp_pkg::INF_Q;
		end else if (issue_s1 && (term < best_q)) begin
			best_q <= term;
		end
		if (ctrl.rd_ld) begin
			row_q <= NW'(row);
			col_q <= NW'(col);
			in_range_q <= wr_in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			p_q <= '0;
			n_last_q <= '0;
			iters_q <= '0;
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= ctrl.issue;
			if (ctrl.run_ld) begin
				if (n_raw == '0) begin
					n_last_q <= '0;
				end else if (32'(n_raw) > MAX_NODES) begin
					n_last_q <= NW'(MAX_NODES - 1);
				end else begin
					n_last_q <= NW'(n_raw - 7'd1);
				end
				if (32'(it_raw) > MAX_ITERATIONS) begin
					iters_q <= IW'(MAX_ITERATIONS);
				end else begin
					iters_q <= IW'(it_raw);
				end
			end
			if (ctrl.k_clr) begin
				k_q <= '0;
			end else if (ctrl.k_inc) begin
				k_q <= k_q + 1'b1;
			end
			if (ctrl.ij_clr) begin
				i_q <= '0;
				j_q <= '0;
			end else if (ctrl.ij_inc) begin
				if (j_q == n_last_q) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (ctrl.p_clr) begin
				p_q <= '0;
			end else if (ctrl.p_inc) begin
				p_q <= p_q + 1'b1;
			end
		end
	end

	assign stat.k_last = (k_q == n_last_q);
	assign stat.ij_last = (i_q == n_last_q) && (j_q == n_last_q);
	assign stat.p_done = (p_q == iters_q);
	assign dist_rdata = dist_rdata_q;
	assign rd_in_range = in_range_q;

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.issue |-> k_q <= n_last_q)
		else $error("k index beyond node count during accumulation");

	a_dist_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.dist_we |-> (i_q <= n_last_q) && (j_q <= n_last_q))
		else $error("distance write outside active matrix");

	a_k_steps: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.issue && !stat.k_last |=> k_q == NW'($past(k_q) + 1'b1))
		else $error("k index did not advance by one");

endmodule

@@ src/min_plus_all_pairs_shortest_paths_top.sv @@
// top level: microcode sequencer, config registers and result register
// write: a write word lands in the adjacency store on acceptance and gives no result
// read: address registered on acceptance, memory read in RDI, result register loaded in RDO
// run: copy, then passes; one k term per cycle, bound by the single read port of each matrix memory
// flow: one word at a time, taken only in the idle step; input open while a result waits
// reset: sequencer idle, result register empty, node_count 64, iteration_count 1; matrices undefined
module min_plus_all_pairs_shortest_paths_top #(
	parameter int MAX_NODES = mpsp_pkg::MAX_NODES_DEF,
	parameter int MAX_ITERATIONS = mpsp_pkg::MAX_ITERATIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [mpsp_pkg::CFG_W-1:0]        cfg_data,
	// input words
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic [5:0]                        row,
	input  logic [5:0]                        col,
	input  logic [mpsp_pkg::WEIGHT_W-1:0]     weight,
	// result words
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mpsp_pkg::WEIGHT_W-1:0]     distance,
	output logic                              run_done
);

	// sequencer state
	mpsp_pkg::step_t step_q, step_next;
	mpsp_pkg::ctrl_t ctrl_rom, ctrl;
	mpsp_pkg::stat_t stat;

	// config registers
	logic [mpsp_pkg::CFG_W-1:0] node_count_q;
	logic [mpsp_pkg::CFG_W-1:0] iteration_count_q;

	// result register
	logic                          out_valid_q;
	logic [mpsp_pkg::WEIGHT_W-1:0] distance_q;
	logic                          run_done_q;

	logic [mpsp_pkg::WEIGHT_W-1:0] dist_rdata;
	logic                          rd_in_range;
	logic                          accept;
	logic                          produce;
	logic                          stall;

	// config writes land at once, no handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= mpsp_pkg::NODE_COUNT_RST;
			iteration_count_q <= mpsp_pkg::ITERATION_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mpsp_pkg::REG_NODE_COUNT: node_count_q <= cfg_data;
				mpsp_pkg::REG_ITERATION_COUNT: iteration_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a word is taken only in the idle step; the result register decouples the output side
	assign in_ready = (step_q == mpsp_pkg::STEP_IDLE);
	assign accept = in_valid && in_ready;

	// control word fetch; command strobes come from the dispatch in the idle step
	assign ctrl_rom = mpsp_pkg::ucode(step_q);
	always_comb begin
		ctrl = ctrl_rom;
		ctrl.adj_we = accept && (func == mpsp_pkg::FUNC_WRITE);
		ctrl.run_ld = accept && (func == mpsp_pkg::FUNC_RUN);
		ctrl.rd_ld = accept && (func == mpsp_pkg::FUNC_READ);
	end

	// result steps hold while the result register is still full
	assign stall = (ctrl_rom.out_run || ctrl_rom.out_read) && out_valid_q && !out_ready;
	assign produce = (ctrl_rom.out_run || ctrl_rom.out_read) && !stall;

	// next step: fall through, jump or dispatch on the function code
	always_comb begin
		step_next = step_q + 4'd1;
		case (ctrl_rom.cond)
			mpsp_pkg::COND_NEXT: step_next = step_q + 4'd1;
			mpsp_pkg::COND_ALWAYS: step_next = ctrl_rom.target;
			mpsp_pkg::COND_K_MORE:
				if (!stat.k_last) step_next = ctrl_rom.target;
			mpsp_pkg::COND_IJ_MORE:
				if (!stat.ij_last) step_next = ctrl_rom.target;
			mpsp_pkg::COND_P_DONE:
				if (stat.p_done) step_next = ctrl_rom.target;
			mpsp_pkg::COND_DISPATCH: begin
				step_next = mpsp_pkg::STEP_IDLE;
				if (accept && (func == mpsp_pkg::FUNC_RUN)) begin
					step_next = mpsp_pkg::STEP_RUN_INIT;
				end else if (accept && (func == mpsp_pkg::FUNC_READ)) begin
					step_next = mpsp_pkg::STEP_RDI;
				end
			end
			default: step_next = mpsp_pkg::STEP_IDLE;
		endcase
		if (stall) begin
			step_next = step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mpsp_pkg::STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

	mpsp_dpath #(
		.MAX_NODES(MAX_NODES),
		.MAX_ITERATIONS(MAX_ITERATIONS)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.row(row),
		.col(col),
		.weight(weight),
		.n_raw(node_count_q),
		.it_raw(iteration_count_q),
		.stat(stat),
		.dist_rdata(dist_rdata),
		.rd_in_range(rd_in_range)
	);

	// result register: run completion carries zero, a read outside the store gives infinity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			run_done_q <= ctrl_rom.out_run;
			if (ctrl_rom.out_run) begin
				distance_q <= '0;
			end else begin
				distance_q <= rd_in_range ? dist_rdata : mpsp_pkg::INF_Q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign distance = distance_q;
	assign run_done = run_done_q;

	a_run_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_done |-> distance == '0)
		else $error("run completion word with nonzero distance");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step_q == mpsp_pkg::STEP_DONE
			|| step_q == mpsp_pkg::STEP_RDO))
		else $error("result produced outside a result step");

	a_run_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == mpsp_pkg::FUNC_RUN)
		|=> step_q == mpsp_pkg::STEP_RUN_INIT)
		else $error("run word not dispatched to run program");

endmodule

@@ sim/tb_min_plus_all_pairs_shortest_paths_top.sv @@
// testbench of the min-plus shortest path engine: directed table, random phases, matrix predictor
module tb_min_plus_all_pairs_shortest_paths_top;

	localparam int WEIGHT_W = mpsp_pkg::WEIGHT_W;
	localparam int CFG_W = mpsp_pkg::CFG_W;
	localparam logic [WEIGHT_W-1:0] INF_Q = mpsp_pkg::INF_Q;
	localparam logic [1:0] FUNC_WRITE = mpsp_pkg::FUNC_WRITE;
	localparam logic [1:0] FUNC_RUN = mpsp_pkg::FUNC_RUN;
	localparam logic [1:0] FUNC_READ = mpsp_pkg::FUNC_READ;
	localparam logic REG_NODE_COUNT = mpsp_pkg::REG_NODE_COUNT;
	localparam logic REG_ITERATION_COUNT = mpsp_pkg::REG_ITERATION_COUNT;

	localparam int SIDE = mpsp_pkg::MAX_NODES_DEF;
	localparam int PASS_CAP = mpsp_pkg::MAX_ITERATIONS_DEF;
	// random traffic stays inside this corner of the store, which is filled first
	localparam int FILL_SIDE = 16;
	localparam int ITEM_TARGET = 1700;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int HOLD_CYCLES = 500;
	// longest correct quiet stretch is one run plus a stall
	localparam int WATCHDOG_LIMIT = 100000;

	// func code that the block ignores
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// row kinds and how a row's result is known
	localparam logic CFG_ROW = 1'b1;
	localparam logic WORD_ROW = 1'b0;
	localparam logic KNOWN = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef struct packed {
		logic [WEIGHT_W-1:0] dist_val;
		logic done;
	} result_t;

	typedef struct packed {
		logic is_cfg;
		logic reg_idx;
		logic [CFG_W-1:0] reg_val;
		logic [1:0] f;
		logic [5:0] r;
		logic [5:0] c;
		logic [WEIGHT_W-1:0] w;
		logic typed;
		logic [WEIGHT_W-1:0] exp_dist;
		logic exp_done;
	} script_row_t;

	// directed part: small known graphs, saturation, config extremes, ignored code
	localparam int SCRIPT_ROWS = 29;
	localparam script_row_t SCRIPT [0:SCRIPT_ROWS-1] = '{
		// two nodes, one pass
		'{CFG_ROW, REG_NODE_COUNT, 7'd2, 2'd0, 6'd0, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{CFG_ROW, REG_ITERATION_COUNT, 7'd1, 2'd0, 6'd0, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_WRITE, 6'd0, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_WRITE, 6'd0, 6'd1, 32'h0001_0000, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_WRITE, 6'd1, 6'd0, 32'hFFFF_FFFE, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_WRITE, 6'd1, 6'd1, INF_Q, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_RUN, 6'd0, 6'd0, 32'h0, KNOWN, 32'h0, 1'b1},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_READ, 6'd0, 6'd0, 32'h0, KNOWN, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_READ, 6'd0, 6'd1, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_READ, 6'd1, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		// near-infinity plus one saturates
		'{WORD_ROW, 1'b0, 7'd0, FUNC_READ, 6'd1, 6'd1, 32'h0, KNOWN, INF_Q, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_UNUSED, 6'd63, 6'd63, INF_Q, PREDICTED, 32'h0, 1'b0},
		// zero passes leave the copy
		'{CFG_ROW, REG_ITERATION_COUNT, 7'd0, 2'd0, 6'd0, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_WRITE, 6'd1, 6'd1, 32'h0000_8000, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_RUN, 6'd0, 6'd0, 32'h0, KNOWN, 32'h0, 1'b1},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_READ, 6'd1, 6'd1, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_READ, 6'd0, 6'd1, 32'h0, PREDICTED, 32'h0, 1'b0},
		// single node, most passes; then a read outside node_count
		'{CFG_ROW, REG_NODE_COUNT, 7'd1, 2'd0, 6'd0, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{CFG_ROW, REG_ITERATION_COUNT, 7'd64, 2'd0, 6'd0, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_WRITE, 6'd0, 6'd0, 32'h0000_0001, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_RUN, 6'd0, 6'd0, 32'h0, KNOWN, 32'h0, 1'b1},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_READ, 6'd0, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_READ, 6'd1, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		// node count zero acts as one, pass count above the cap saturates
		'{CFG_ROW, REG_NODE_COUNT, 7'd0, 2'd0, 6'd0, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{CFG_ROW, REG_ITERATION_COUNT, 7'd127, 2'd0, 6'd0, 6'd0, 32'h0, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF, PREDICTED, 32'h0, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_RUN, 6'd0, 6'd0, 32'h0, KNOWN, 32'h0, 1'b1},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_READ, 6'd0, 6'd0, 32'h0, KNOWN, INF_Q, 1'b0},
		'{WORD_ROW, 1'b0, 7'd0, FUNC_WRITE, 6'd63, 6'd63, INF_Q, PREDICTED, 32'h0, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] func;
	logic [5:0] row;
	logic [5:0] col;
	logic [WEIGHT_W-1:0] weight;
	logic out_valid;
	logic out_ready;
	logic [WEIGHT_W-1:0] distance;
	logic run_done;

	min_plus_all_pairs_shortest_paths_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.row(row),
		.col(col),
		.weight(weight),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distance(distance),
		.run_done(run_done)
	);

	// predictor state: both matrices and the two config registers
	logic [WEIGHT_W-1:0] weight_mat [0:SIDE*SIDE-1];
	logic [WEIGHT_W-1:0] dist_mat [0:SIDE*SIDE-1];
	logic [CFG_W-1:0] node_reg;
	logic [CFG_W-1:0] pass_reg;

	// result words still owed by the block, oldest first
	result_t awaited [$];

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned cfg_writes;
	int unsigned writes_seen;
	int unsigned runs_seen;
	int unsigned reads_seen;
	int unsigned ignored_seen;
	int unsigned widest_run;
	int unsigned deepest_run;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// q16.16 add where infinity absorbs and overflow clamps to infinity
	function automatic logic [WEIGHT_W-1:0] sat_sum(input logic [WEIGHT_W-1:0] a,
			input logic [WEIGHT_W-1:0] b);
		logic [WEIGHT_W:0] s;
		if (a == INF_Q || b == INF_Q)
			return INF_Q;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, INF_Q})
			return INF_Q;
		return s[WEIGHT_W-1:0];
	endfunction

	// copy weights into distances, then in-place min-plus passes in row-major order
	function automatic void run_min_plus_passes();
		int unsigned n, passes, p, i, j, k;
		logic [WEIGHT_W-1:0] best, s;
		n = node_reg;
		if (n < 1)
			n = 1;
		if (n > SIDE)
			n = SIDE;
		passes = pass_reg;
		if (passes > PASS_CAP)
			passes = PASS_CAP;
		if (n > widest_run)
			widest_run = n;
		if (passes > deepest_run)
			deepest_run = passes;
		for (i = 0; i < n; i++)
			for (j = 0; j < n; j++)
				dist_mat[i*SIDE+j] = weight_mat[i*SIDE+j];
		for (p = 0; p < passes; p++)
			for (i = 0; i < n; i++)
				for (j = 0; j < n; j++) begin
					best = INF_Q;
					for (k = 0; k < n; k++) begin
						s = sat_sum(weight_mat[k*SIDE+j], dist_mat[i*SIDE+k]);
						if (s < best)
							best = s;
					end
					dist_mat[i*SIDE+j] = best;
				end
	endfunction

	// apply one accepted word to the matrices; returns 1 when it owes a result
	// row and col are 6 bits, so the out-of-range address case cannot arise here
	function automatic bit solve_word(input logic [1:0] f, input logic [5:0] r,
			input logic [5:0] c, input logic [WEIGHT_W-1:0] w, output result_t res);
		res = '0;
		case (f)
			FUNC_WRITE: begin
				writes_seen++;
				weight_mat[int'(r)*SIDE+int'(c)] = w;
				return 1'b0;
			end
			FUNC_RUN: begin
				runs_seen++;
				run_min_plus_passes();
				res.done = 1'b1;
				return 1'b1;
			end
			FUNC_READ: begin
				reads_seen++;
				res.dist_val = dist_mat[int'(r)*SIDE+int'(c)];
				return 1'b1;
			end
			default: begin
				ignored_seen++;
				return 1'b0;
			end
		endcase
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 85)
			return $urandom_range(1, 2);
		if (k < 96)
			return $urandom_range(3, 8);
		return $urandom_range(20, 80);
	endfunction

	// weights lean toward small values, zero, infinity and near-infinity
	function automatic logic [WEIGHT_W-1:0] pick_weight();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 15)
			return INF_Q;
		if (k < 25)
			return '0;
		if (k < 35)
			return {16'hFFFF, 16'($urandom)};
		if (k < 75)
			return 32'($urandom_range(0, 32'h0008_0000));
		return $urandom;
	endfunction

	task automatic report_mismatch(input string field, input logic [WEIGHT_W-1:0] want,
			input logic [WEIGHT_W-1:0] got);
		mismatches++;
		$display("mismatch at result word %0d: %s expected %h got %h",
			results_seen, field, want, got);
	endtask

	// offer one input word, wait for the handshake, then predict its result
	task automatic send_word(input logic [1:0] f, input logic [5:0] r, input logic [5:0] c,
			input logic [WEIGHT_W-1:0] w, input bit typed, input result_t known,
			input bit steady);
		int unsigned gap;
		result_t predicted;
		bit owes;
		gap = steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = f;
		row = r;
		col = c;
		weight = w;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		owes = solve_word(f, r, c, w, predicted);
		// typed rows keep their own answer; the predictor still tracks the matrices
		if (owes)
			awaited.push_back(typed ? known : predicted);
	endtask

	// config writes only land once the block is idle
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		// a trailing write word owes no result, give it time to land
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_NODE_COUNT)
			node_reg = val;
		else
			pass_reg = val;
		cfg_writes++;
	endtask

	// result checker: every accepted result word against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (awaited.size() == 0) begin
				report_mismatch("result word with nothing pending, distance", '0, distance);
			end else begin
				want = awaited.pop_front();
				if (distance !== want.dist_val)
					report_mismatch("distance", want.dist_val, distance);
				if (run_done !== want.done)
					report_mismatch("run_done", {31'd0, want.done}, {31'd0, run_done});
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", idle_cycles);
				$display("FAIL min_plus_all_pairs_shortest_paths_top");
				$finish;
			end
		end
	end

	// receiver: ready bursts and random stalls, plus two long hold-offs that
	// let the block fill up and push back on the sender
	initial begin
		int unsigned burst, gap, holds_done;
		out_ready = 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (holds_done < 2 && results_seen >= 150 + 550 * holds_done) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end
			out_ready = 1'b1;
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
			repeat (burst) @(negedge clk);
			gap = pick_gap();
			if (gap != 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	// main sequence
	initial begin
		script_row_t srow;
		int unsigned phase, n_cfg, it_cfg, eff, count, k, run_pct, r, c, random_words;
		bit steady;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NODE_COUNT;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_WRITE;
		row = '0;
		col = '0;
		weight = '0;
		node_reg = mpsp_pkg::NODE_COUNT_RST;
		pass_reg = mpsp_pkg::ITERATION_COUNT_RST;
		mismatches = 0;
		results_seen = 0;
		cfg_writes = 0;
		writes_seen = 0;
		runs_seen = 0;
		reads_seen = 0;
		ignored_seen = 0;
		widest_run = 0;
		deepest_run = 0;
		idle_cycles = 0;
		random_words = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			srow = SCRIPT[i];
			if (srow.is_cfg)
				write_reg(srow.reg_idx, srow.reg_val);
			else
				send_word(srow.f, srow.r, srow.c, srow.w, srow.typed,
					'{dist_val: srow.exp_dist, done: srow.exp_done}, 1'b0);
		end

		// random phases: a few fixed extremes first, then random settings
		// the first phase writes every weight of the filled corner and copies it,
		// so from then on every entry that traffic touches holds a written value
		for (phase = 0; phase < 4 || random_words < ITEM_TARGET; phase++) begin
			case (phase)
				0: begin
					n_cfg = FILL_SIDE;
					it_cfg = 0;
				end
				1: begin
					n_cfg = FILL_SIDE;
					it_cfg = 1;
				end
				2: begin
					n_cfg = 3;
					it_cfg = 64;
				end
				3: begin
					n_cfg = 5;
					it_cfg = 100;
				end
				default: begin
					k = $urandom_range(0, 99);
					if (k < 60)
						n_cfg = $urandom_range(1, 6);
					else if (k < 90)
						n_cfg = $urandom_range(7, 10);
					else
						n_cfg = $urandom_range(11, FILL_SIDE);
					if (n_cfg > 10)
						it_cfg = $urandom_range(0, 2);
					else if ($urandom_range(0, 9) == 0)
						it_cfg = $urandom_range(4, 8);
					else
						it_cfg = $urandom_range(0, 3);
				end
			endcase
			write_reg(REG_NODE_COUNT, 7'(n_cfg));
			write_reg(REG_ITERATION_COUNT, 7'(it_cfg));
			eff = (n_cfg == 0) ? 1 : ((n_cfg > SIDE) ? SIDE : n_cfg);
			// larger runs are slow, keep them rare
			run_pct = (eff > 16) ? 2 : 10;
			steady = ($urandom_range(0, 3) == 0);

			if (phase == 0) begin
				for (r = 0; r < FILL_SIDE; r++)
					for (c = 0; c < FILL_SIDE; c++) begin
						send_word(FUNC_WRITE, 6'(r), 6'(c), pick_weight(), 1'b0, '0, steady);
						random_words++;
					end
				send_word(FUNC_RUN, '0, '0, '0, 1'b0, '0, steady);
				random_words++;
			end

			// well-formed traffic: weight updates, runs and distance reads
			count = $urandom_range(30, 90);
			repeat (count) begin
				k = $urandom_range(0, 99);
				if (k < 30) begin
					send_word(FUNC_WRITE, 6'($urandom_range(0, eff - 1)),
						6'($urandom_range(0, eff - 1)), pick_weight(), 1'b0, '0, steady);
					random_words++;
				end else if (k < 35) begin
					// store entries outside node_count are still addressed
					send_word(FUNC_WRITE, 6'($urandom_range(0, FILL_SIDE - 1)),
						6'($urandom_range(0, FILL_SIDE - 1)), pick_weight(),
						1'b0, '0, steady);
					random_words++;
				end else if (k < 35 + run_pct) begin
					send_word(FUNC_RUN, 6'($urandom), 6'($urandom), $urandom, 1'b0, '0, steady);
					random_words++;
				end else if (k < 92) begin
					send_word(FUNC_READ, 6'($urandom_range(0, eff - 1)),
						6'($urandom_range(0, eff - 1)), $urandom, 1'b0, '0, steady);
					random_words++;
				end else if (k < 97) begin
					send_word(FUNC_READ, 6'($urandom_range(0, FILL_SIDE - 1)),
						6'($urandom_range(0, FILL_SIDE - 1)), $urandom, 1'b0, '0, steady);
					random_words++;
				end else begin
					// noise: unused code, no result
					send_word(FUNC_UNUSED, 6'($urandom), 6'($urandom), $urandom,
						1'b0, '0, steady);
				end
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d writes, %0d runs (up to %0d nodes, %0d passes), %0d reads, %0d ignored",
			writes_seen, runs_seen, widest_run, deepest_run, reads_seen, ignored_seen);
		$display("%0d config writes over %0d phases, %0d result words checked, %0d mismatches",
			cfg_writes, phase, results_seen, mismatches);
		if (mismatches == 0)
			$display("PASS min_plus_all_pairs_shortest_paths_top");
		else
			$display("FAIL min_plus_all_pairs_shortest_paths_top");
		$finish;
	end

endmodule

@@ filelist.f @@
src/mpsp_pkg.sv
src/mpsp_dpath.sv
src/min_plus_all_pairs_shortest_paths_top.sv
sim/tb_min_plus_all_pairs_shortest_paths_top.sv
